>>> rtl/bfr_pkg.sv
// shared types and character codes for the bisync frame receiver
package bfr_pkg;

    // line characters, ebcdic
    localparam logic [7:0] CH_SYN   = 8'h32;
    localparam logic [7:0] CH_EOT   = 8'h37;
    localparam logic [7:0] CH_NAK   = 8'h3D;
    localparam logic [7:0] CH_DLE   = 8'h10;
    localparam logic [7:0] CH_SOH   = 8'h01;
    localparam logic [7:0] CH_STX   = 8'h02;
    localparam logic [7:0] CH_ETB   = 8'h26;
    localparam logic [7:0] CH_ETX   = 8'h03;
    localparam logic [7:0] CH_ENQ   = 8'h2D;
    localparam logic [7:0] CH_PAD   = 8'hFF;

    // second character of a dle pair
    localparam logic [7:0] CH_ACK0  = 8'h70;
    localparam logic [7:0] CH_ACK1  = 8'h61;
    localparam logic [7:0] CH_WACK  = 8'h6B;
    localparam logic [7:0] CH_RVI   = 8'h7C;

    // header bytes
    localparam logic [7:0] HDR_LEAD   = 8'h6C;
    localparam logic [7:0] HDR_STATUS = 8'hD9;
    localparam logic [7:0] HDR_TEST   = 8'h61;

    // frame kinds
    localparam logic [3:0] K_EOT    = 4'd0;
    localparam logic [3:0] K_NAK    = 4'd1;
    localparam logic [3:0] K_ACK0   = 4'd2;
    localparam logic [3:0] K_ACK1   = 4'd3;
    localparam logic [3:0] K_WACK   = 4'd4;
    localparam logic [3:0] K_RVI    = 4'd5;
    localparam logic [3:0] K_STATUS = 4'd6;
    localparam logic [3:0] K_TEST   = 4'd7;
    localparam logic [3:0] K_BADHDR = 4'd8;
    localparam logic [3:0] K_TEXT   = 4'd9;
    localparam logic [3:0] K_POLL   = 4'd10;

    // one step's outcome, from the frame fsm to the result register
    typedef struct packed {
        logic       emit;
        logic [3:0] kind;
        logic       hunt;
    } t_result;

endpackage

>>> rtl/bisync_frame_receiver_core.sv
// top level of the bisync frame receiver: input register, frame fsm, result register
//
// input channel: one received ebcdic line character per item on i_data_byte,
//   handshake i_in_valid / o_in_ready
// output channel: one item per recognized frame, o_frame_kind and o_enter_hunt,
//   handshake o_out_valid / i_out_ready
// an input item is registered at acceptance and stepped through the frame fsm
//   once the result slot is free; the result register loads at the edge that
//   ends that step, so o_out_valid rises once the closing pad item has stepped
// throughput: one item per cycle while results are taken, set by the single fsm step between the input
//   and result registers
// most items produce no result; only the pad that closes a frame does
// when the receiver holds off (i_out_ready low with a result waiting), the fsm
//   step stalls for every item, even one that would produce no result; the input
//   register takes at most one more item, then o_in_ready drops until the result
//   is taken, so nothing is lost or reordered
// reset (i_rst_n low, synchronous): both registers empty, fsm back to hunting
//   for the first syn, pending kind and header bytes cleared
module bisync_frame_receiver_core
    import bfr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_data_byte,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [3:0] o_frame_kind,
    output logic       o_enter_hunt
);

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_data;

    // result register
    logic       r_out_valid;
    logic [3:0] r_out_kind;
    logic       r_out_hunt;

    logic       out_free;
    logic       step;
    logic       in_take;
    t_result    step_result;

    // result slot is free when empty or being taken this cycle
    assign out_free   = !r_out_valid || i_out_ready;
    // the fsm steps on the held item whenever its possible result has room
    assign step       = r_in_valid && out_free;
    assign o_in_ready = !r_in_valid || out_free;
    assign in_take    = i_in_valid && o_in_ready;

    bfr_fsm u_fsm (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_data   (r_in_data),
        .o_result (step_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    // payload holds no reset
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_data <= i_data_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= step_result.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step_result.emit) begin
            r_out_kind <= step_result.kind;
            r_out_hunt <= step_result.hunt;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_frame_kind = r_out_kind;
    assign o_enter_hunt = r_out_hunt;

endmodule

>>> rtl/bfr_fsm.sv
// frame state machine: classifies the frame one character per step
module bfr_fsm
    import bfr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_data,
    output t_result    o_result
);

    typedef enum logic [3:0] {
        PH_HUNT1 = 4'd0,
        PH_HUNT2 = 4'd1,
        PH_CTRL  = 4'd2,
        PH_PAD   = 4'd3,
        PH_DLE2  = 4'd4,
        PH_HDR   = 4'd5,
        PH_TEXT  = 4'd6,
        PH_ADDR  = 4'd7,
        PH_STX   = 4'd8,
        PH_CRC   = 4'd9,
        PH_ENQ   = 4'd10
    } t_phase;

    t_phase     r_phase, n_phase;
    logic [1:0] r_left, n_left;
    logic [3:0] r_kind, n_kind;
    logic [7:0] r_hdr1, n_hdr1;
    logic [7:0] r_hdr2, n_hdr2;
    logic [1:0] left_dec;

    assign left_dec = r_left - 2'd1;

    always_comb begin
        n_phase  = r_phase;
        n_left   = r_left;
        n_kind   = r_kind;
        n_hdr1   = r_hdr1;
        n_hdr2   = r_hdr2;
        o_result = '{emit: 1'b0, kind: r_kind,
                     hunt: (r_kind == K_EOT) || (r_kind == K_NAK)};
        case (r_phase)
            PH_HUNT1: begin
                if (i_data == CH_SYN) n_phase = PH_HUNT2;
            end
            PH_HUNT2: begin
                if (i_data == CH_SYN) n_phase = PH_CTRL;
            end
            PH_CTRL: begin
                if (i_data == CH_EOT) begin
                    n_kind  = K_EOT;
                    n_phase = PH_PAD;
                end else if (i_data == CH_NAK) begin
                    n_kind  = K_NAK;
                    n_phase = PH_PAD;
                end else if (i_data == CH_DLE) begin
                    n_phase = PH_DLE2;
                end else if (i_data == CH_SOH) begin
                    n_left  = 2'd2;
                    n_phase = PH_HDR;
                end else if (i_data == CH_STX) begin
                    n_kind  = K_TEXT;
                    n_phase = PH_TEXT;
                end else begin
                    // first of four address bytes
                    n_kind  = K_POLL;
                    n_left  = 2'd3;
                    n_phase = PH_ADDR;
                end
            end
            PH_PAD: begin
                o_result.emit = (i_data == CH_PAD);
                n_phase       = PH_HUNT1;
            end
            PH_DLE2: begin
                n_phase = PH_PAD;
                if (i_data == CH_ACK0)      n_kind = K_ACK0;
                else if (i_data == CH_ACK1) n_kind = K_ACK1;
                else if (i_data == CH_WACK) n_kind = K_WACK;
                else if (i_data == CH_RVI)  n_kind = K_RVI;
                else                        n_phase = PH_HUNT1;
            end
            PH_HDR: begin
                if (r_left == 2'd2) n_hdr1 = i_data;
                else                n_hdr2 = i_data;
                n_left = left_dec;
                if (left_dec == 2'd0) begin
                    if (n_hdr1 != HDR_LEAD)       n_kind = K_BADHDR;
                    else if (n_hdr2 == HDR_STATUS) n_kind = K_STATUS;
                    else if (n_hdr2 == HDR_TEST)   n_kind = K_TEST;
                    else                           n_kind = K_BADHDR;
                    n_phase = PH_STX;
                end
            end
            PH_TEXT: begin
                if (i_data == CH_ETB || i_data == CH_ETX) begin
                    n_left  = 2'd2;
                    n_phase = PH_CRC;
                end
            end
            PH_ADDR: begin
                n_left = left_dec;
                if (left_dec == 2'd0) n_phase = PH_ENQ;
            end
            PH_STX: begin
                n_phase = (i_data == CH_STX) ? PH_TEXT : PH_HUNT1;
            end
            PH_CRC: begin
                n_left = left_dec;
                if (left_dec == 2'd0) n_phase = PH_PAD;
            end
            PH_ENQ: begin
                n_phase = (i_data == CH_ENQ) ? PH_PAD : PH_HUNT1;
            end
            default: begin
                n_phase = PH_HUNT1;
            end
        endcase
        if (!i_step) o_result.emit = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT1;
            r_left  <= 2'd0;
            r_kind  <= K_EOT;
            r_hdr1  <= 8'd0;
            r_hdr2  <= 8'd0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_left  <= n_left;
            r_kind  <= n_kind;
            r_hdr1  <= n_hdr1;
            r_hdr2  <= n_hdr2;
        end
    end

endmodule
